/* sv/assert_macros.svh */
// Assertion macros shared by the profiler RTL.
// Needs clk and rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define SIP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SIP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Implication after a fixed number of cycles.
`define SIP_ASSERT_AFTER(label, ante, dly, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
        else $error(msg);

`endif

/* sv/sip_pkg.sv */
// Shared types and constants of the slot interval profiler.
// No dependencies.
`default_nettype none

package sip_pkg;

    localparam int StampW   = 63;
    localparam int CountW   = 32;
    localparam int TotalW   = 64;
    localparam int CmdW     = 3;
    localparam int SlotW    = 8;
    localparam int DivSteps = 64;

    localparam logic [CmdW-1:0] CMD_START = 3'd0;
    localparam logic [CmdW-1:0] CMD_END   = 3'd1;
    localparam logic [CmdW-1:0] CMD_MARK  = 3'd2;
    localparam logic [CmdW-1:0] CMD_READ  = 3'd3;
    localparam logic [CmdW-1:0] CMD_CLEAR = 3'd4;

    // One slot as stored in the table.
    typedef struct packed {
        logic [62:0] start;
        logic [31:0] count;
        logic [63:0] total;
        logic [62:0] worst;
        logic [62:0] last;
    } rec_t;

    // Controller to datapath.
    typedef struct packed {
        logic capture;
        logic load;
        logic write;
        logic clear;
        logic div_start;
        logic res_load;
    } dp_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic [2:0] op;
        logic       slot_ok;
        logic       cnt_zero;
        logic       div_done;
    } dp_stat_t;

endpackage

`default_nettype wire

/* sv/sip_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none

module sip_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* sv/sip_div.sv */
// Restoring divider, one quotient bit per cycle: 64-bit magnitude by 32-bit count.
// Uses sip_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module sip_div (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] dividend,
    input  wire logic [31:0] divisor,
    output logic             done,
    output logic      [63:0] quotient
);

    localparam int StepW  = $clog2(sip_pkg::DivSteps);
    localparam int DivLat = sip_pkg::DivSteps + 1;

    logic [31:0]      rem_reg;
    logic [63:0]      quo_reg;
    logic [31:0]      den_reg;
    logic [StepW-1:0] step_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [32:0] shifted;
    logic [32:0] diff;

    assign shifted = {rem_reg, quo_reg[63]};
    assign diff    = shifted - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= StepW'(sip_pkg::DivSteps - 1);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            // keep the shifted remainder when the trial subtract goes negative
            if (!diff[32])
            begin
                rem_reg <= diff[31:0];
                quo_reg <= {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[31:0];
                quo_reg <= {quo_reg[62:0], 1'b0};
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

    `SIP_ASSERT_AFTER(a_div_latency, start, DivLat, done_reg, "divider latency off")
    `SIP_ASSERT_NOW(a_done_idle, done_reg, !busy_reg && !start, "done while busy")

endmodule

`default_nettype wire

/* sv/sip_dpath.sv */
// Datapath: slot table, interval arithmetic, divider and result register.
// Uses sip_pkg, sip_ram, sip_div and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module sip_dpath #(
    parameter int SLOTS = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire sip_pkg::dp_cmd_t      ctl,
    output sip_pkg::dp_stat_t          stat,
    input  wire logic [2:0]            command,
    input  wire logic [7:0]            slot,
    input  wire logic [62:0]           now_ticks,
    output logic                       slot_empty,
    output logic      [31:0]           sample_count,
    output logic      [62:0]           worst_ticks,
    output logic signed [63:0]         total_ticks,
    output logic signed [63:0]         average_ticks,
    output logic                       last_valid,
    output logic signed [63:0]         ticks_since_last
);

    localparam int AddrW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int ValidN = 1 << AddrW;
    localparam int RecW   = $bits(sip_pkg::rec_t);

    logic [2:0]        op_reg;
    logic [7:0]        slot_reg;
    logic [62:0]       now_reg;
    sip_pkg::rec_t     rec_reg;
    logic [63:0]       delta_reg;
    logic [63:0]       since_reg;
    logic [ValidN-1:0] valid_reg;
    logic [ValidN-1:0] valid_next;

    logic              empty_reg;
    logic [31:0]       count_reg;
    logic [62:0]       worst_reg;
    logic [63:0]       total_reg;
    logic [63:0]       avg_reg;
    logic              lastv_reg;
    logic [63:0]       since_out_reg;

    logic [AddrW-1:0]  idx;
    logic              slot_ok;
    logic              hit;
    logic [RecW-1:0]   rd_data;
    sip_pkg::rec_t     rec_rd;
    sip_pkg::rec_t     rec_new;
    logic [63:0]       magnitude;
    logic              div_done;
    logic [63:0]       quotient;
    logic              has_last;

    assign idx     = slot_reg[AddrW-1:0];
    assign slot_ok = {1'b0, slot_reg} < 9'(SLOTS);
    assign hit     = slot_ok && valid_reg[idx];
    assign rec_rd  = hit ? sip_pkg::rec_t'(rd_data) : '0;

    sip_ram #(
        .WIDTH (RecW),
        .DEPTH (SLOTS)
    ) u_table (
        .clk   (clk),
        .we    (ctl.write),
        .waddr (idx),
        .wdata (rec_new),
        .re    (ctl.capture),
        .raddr (slot[AddrW-1:0]),
        .rdata (rd_data)
    );

    always_comb
    begin
        rec_new = rec_reg;
        case (op_reg)
            sip_pkg::CMD_START:
            begin
                rec_new.start = now_reg;
            end
            sip_pkg::CMD_END:
            begin
                // a negative interval never becomes the worst
                if (!delta_reg[63] && (delta_reg[62:0] > rec_reg.worst))
                begin
                    rec_new.worst = delta_reg[62:0];
                end
                rec_new.total = rec_reg.total + delta_reg;
                if (rec_reg.count != '1)
                begin
                    rec_new.count = rec_reg.count + 1'b1;
                end
            end
            sip_pkg::CMD_MARK:
            begin
                rec_new.last = now_reg;
            end
            default:
            begin
                rec_new = rec_reg;
            end
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (ctl.clear)
        begin
            valid_next = '0;
        end
        else if (ctl.write)
        begin
            valid_next[idx] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            op_reg    <= sip_pkg::CMD_START;
        end
        else
        begin
            valid_reg <= valid_next;
            if (ctl.capture)
            begin
                op_reg <= command;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            slot_reg <= slot;
            now_reg  <= now_ticks;
        end
        if (ctl.load)
        begin
            rec_reg   <= rec_rd;
            delta_reg <= {1'b0, now_reg} - {1'b0, rec_rd.start};
            since_reg <= {1'b0, now_reg} - {1'b0, rec_rd.last};
        end
    end

    assign magnitude = rec_reg.total[63] ? (64'd0 - rec_reg.total) : rec_reg.total;

    sip_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctl.div_start),
        .dividend (magnitude),
        .divisor  (rec_reg.count),
        .done     (div_done),
        .quotient (quotient)
    );

    assign has_last = rec_reg.last != '0;

    always_ff @(posedge clk)
    begin
        if (ctl.res_load)
        begin
            empty_reg     <= rec_reg.count == '0;
            count_reg     <= rec_reg.count;
            worst_reg     <= rec_reg.worst;
            total_reg     <= rec_reg.total;
            lastv_reg     <= has_last;
            since_out_reg <= has_last ? since_reg : 64'd0;
            if (rec_reg.count == '0)
            begin
                avg_reg <= 64'd0;
            end
            else
            begin
                // restore the sign of the total
                avg_reg <= rec_reg.total[63] ? (64'd0 - quotient) : quotient;
            end
        end
    end

    assign stat.op       = op_reg;
    assign stat.slot_ok  = slot_ok;
    assign stat.cnt_zero = rec_reg.count == '0;
    assign stat.div_done = div_done;

    assign slot_empty       = empty_reg;
    assign sample_count     = count_reg;
    assign worst_ticks      = worst_reg;
    assign total_ticks      = total_reg;
    assign average_ticks    = avg_reg;
    assign last_valid       = lastv_reg;
    assign ticks_since_last = since_out_reg;

    `SIP_ASSERT_NEXT(a_clear_empties, ctl.clear, valid_reg == '0, "clear left a slot live")
    `SIP_ASSERT_NOW(a_write_in_range, ctl.write, slot_ok, "write to a slot out of range")

endmodule

`default_nettype wire

/* sv/sip_ctrl.sv */
// Controller state machine: sequences lookup, update, division and result hand-off.
// Uses sip_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module sip_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output sip_pkg::dp_cmd_t       ctl,
    input  wire sip_pkg::dp_stat_t stat
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOAD = 3'd1;
    localparam logic [2:0] S_EXEC = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_RES  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       accept;
    logic       is_read;
    logic       is_update;

    assign accept    = in_valid && (state_reg == S_IDLE);
    assign is_read   = (stat.op == sip_pkg::CMD_READ) && stat.slot_ok;
    assign is_update = stat.slot_ok && ((stat.op == sip_pkg::CMD_START) ||
                                        (stat.op == sip_pkg::CMD_END) ||
                                        (stat.op == sip_pkg::CMD_MARK));

    always_comb
    begin
        ctl.capture   = accept;
        ctl.load      = state_reg == S_LOAD;
        ctl.write     = (state_reg == S_EXEC) && is_update;
        ctl.clear     = (state_reg == S_EXEC) && (stat.op == sip_pkg::CMD_CLEAR);
        ctl.div_start = (state_reg == S_EXEC) && is_read && !stat.cnt_zero;
        ctl.res_load  = (state_reg == S_RES) && (!out_valid_reg || !out_stall);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (is_read)
                begin
                    state_next = stat.cnt_zero ? S_RES : S_DIV;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_DIV:
            begin
                if (stat.div_done)
                begin
                    state_next = S_RES;
                end
            end
            S_RES:
            begin
                // hold until the result register is free
                if (ctl.res_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctl.res_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = state_reg != S_IDLE;
    assign out_valid = out_valid_reg;

    `SIP_ASSERT_NEXT(a_accept_load, accept, state_reg == S_LOAD, "accept did not start lookup")
    `SIP_ASSERT_NOW(a_res_read, state_reg == S_RES, stat.op == sip_pkg::CMD_READ,
                    "result stage entered for a non-read item")

endmodule

`default_nettype wire

/* sv/slot_interval_profiler.sv */
// Slot interval profiler: start/end/mark/clear go through the load and exec states to idle.
// A read of an empty slot goes from exec straight to the result state; with samples it
// waits on the 64-step serial divider of total by count. One item is in work at a time.
// Reset clears every slot's valid bit at once, so all slots read as zero; no clearing pass.
// Uses sip_pkg, sip_ctrl, sip_dpath.
`default_nettype none

module slot_interval_profiler #(
    parameter int SLOTS = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [2:0]         command,
    input  wire logic [7:0]         slot,
    input  wire logic [62:0]        now_ticks,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic                    slot_empty,
    output logic      [31:0]        sample_count,
    output logic      [62:0]        worst_ticks,
    output logic signed [63:0]      total_ticks,
    output logic signed [63:0]      average_ticks,
    output logic                    last_valid,
    output logic signed [63:0]      ticks_since_last
);

    sip_pkg::dp_cmd_t  ctl;
    sip_pkg::dp_stat_t stat;

    sip_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .ctl       (ctl),
        .stat      (stat)
    );

    sip_dpath #(
        .SLOTS (SLOTS)
    ) u_dpath (
        .clk              (clk),
        .rst_n            (rst_n),
        .ctl              (ctl),
        .stat             (stat),
        .command          (command),
        .slot             (slot),
        .now_ticks        (now_ticks),
        .slot_empty       (slot_empty),
        .sample_count     (sample_count),
        .worst_ticks      (worst_ticks),
        .total_ticks      (total_ticks),
        .average_ticks    (average_ticks),
        .last_valid       (last_valid),
        .ticks_since_last (ticks_since_last)
    );

endmodule

`default_nettype wire

/* test/tb_top.sv */
// Testbench for slot_interval_profiler: directed and random command traffic with
// a behavioral model of the slot table checking every read report.
// Depends on sip_pkg and the slot_interval_profiler RTL.
`default_nettype none

module tb_top;

    localparam int SLOTS = 16;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int TAIL_CYCLES = 150;
    localparam int MAX_PRINTS = 40;
    localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
    localparam logic [2:0] CMD_SPARE_LAST = 3'd7;
    localparam logic [62:0] STAMP_MAX = '1;

    typedef struct packed {
        logic        empty;
        logic [31:0] count;
        logic [62:0] worst;
        logic [63:0] total;
        logic [63:0] average;
        logic        last_ok;
        logic [63:0] since;
    } slot_report_t;

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic [2:0] command;
    logic [7:0] slot;
    logic [62:0] now_ticks;
    logic out_valid;
    logic out_stall;
    logic slot_empty;
    logic [31:0] sample_count;
    logic [62:0] worst_ticks;
    logic signed [63:0] total_ticks;
    logic signed [63:0] average_ticks;
    logic last_valid;
    logic signed [63:0] ticks_since_last;

    // model copy of the slot table
    logic [62:0] model_start[SLOTS];
    logic [31:0] model_count[SLOTS];
    logic [63:0] model_total[SLOTS];
    logic [62:0] model_worst[SLOTS];
    logic [62:0] model_last[SLOTS];

    slot_report_t pending_reports[$];
    slot_report_t report_want;

    bit open_slot[SLOTS];
    bit idling_on;
    logic [62:0] tick_clock;
    int error_count;
    int items_sent;
    int reports_checked;
    int cycle_count;
    int stall_left;

    slot_interval_profiler #(.SLOTS(SLOTS)) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .command(command),
        .slot(slot),
        .now_ticks(now_ticks),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .slot_empty(slot_empty),
        .sample_count(sample_count),
        .worst_ticks(worst_ticks),
        .total_ticks(total_ticks),
        .average_ticks(average_ticks),
        .last_valid(last_valid),
        .ticks_since_last(ticks_since_last)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_top: errors");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        if (error_count < MAX_PRINTS)
            $display("MISMATCH @%0d: %s", cycle_count, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got 0x%h want 0x%h", name, got, want));
    endtask

    // signed total over unsigned count, truncated toward zero
    function automatic logic [63:0] truncated_average(input logic [63:0] total,
                                                      input logic [31:0] count);
        logic [63:0] mag;
        logic [63:0] quot;
        mag = total[63] ? -total : total;
        quot = mag / {32'b0, count};
        return total[63] ? -quot : quot;
    endfunction

    task automatic clear_model();
        for (int i = 0; i < SLOTS; i++)
        begin
            model_start[i] = '0;
            model_count[i] = '0;
            model_total[i] = '0;
            model_worst[i] = '0;
            model_last[i] = '0;
            open_slot[i] = 1'b0;
        end
    endtask

    task automatic predict_item(input logic [2:0] cmd, input logic [7:0] s,
                                input logic [62:0] now);
        logic [63:0] delta;
        slot_report_t rep;
        if (cmd == sip_pkg::CMD_CLEAR)
            clear_model();
        else if (cmd <= sip_pkg::CMD_READ && s < SLOTS)
        begin
            case (cmd)
                sip_pkg::CMD_START: model_start[s] = now;
                sip_pkg::CMD_END:
                begin
                    delta = {1'b0, now} - {1'b0, model_start[s]};
                    // negative intervals count toward the total and the count, never the worst
                    if (!delta[63] && delta > {1'b0, model_worst[s]})
                        model_worst[s] = delta[62:0];
                    model_total[s] = model_total[s] + delta;
                    if (model_count[s] != '1)
                        model_count[s] = model_count[s] + 1;
                end
                sip_pkg::CMD_MARK: model_last[s] = now;
                default:
                begin
                    rep.empty = (model_count[s] == '0);
                    rep.count = model_count[s];
                    rep.worst = model_worst[s];
                    rep.total = model_total[s];
                    rep.average = rep.empty ? 64'd0
                                : truncated_average(model_total[s], model_count[s]);
                    rep.last_ok = (model_last[s] != '0);
                    rep.since = rep.last_ok ? ({1'b0, now} - {1'b0, model_last[s]}) : 64'd0;
                    pending_reports.push_back(rep);
                end
            endcase
        end
    endtask

    // drive one item at the falling edge, hold it until accepted
    task automatic send_item(input logic [2:0] cmd, input logic [7:0] s,
                             input logic [62:0] now);
        @(negedge clk);
        if (idling_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clk);
        end
        in_valid <= 1'b1;
        command <= cmd;
        slot <= s;
        now_ticks <= now;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        items_sent++;
        predict_item(cmd, s, now);
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [62:0] next_stamp();
        int pick;
        logic [63:0] wide;
        pick = $urandom_range(0, 39);
        wide = {$urandom, $urandom};
        if (pick == 0)
            return wide[62:0];
        if (pick == 1)
            return '0;
        if (pick == 2)
            return STAMP_MAX - 63'($urandom_range(0, 1000));
        tick_clock = tick_clock + 63'($urandom_range(1, 400));
        return tick_clock;
    endfunction

    // mostly paired start/end per slot, with reads, marks and some noise
    task automatic send_random_item();
        int pick;
        logic [7:0] s;
        logic [62:0] stamp;
        pick = $urandom_range(0, 99);
        s = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 3))
                                        : 8'($urandom_range(0, SLOTS - 1));
        stamp = next_stamp();
        if (pick < 55)
        begin
            if (open_slot[s] || pick < 3)
            begin
                send_item(sip_pkg::CMD_END, s, stamp);
                open_slot[s] = 1'b0;
            end
            else
            begin
                send_item(sip_pkg::CMD_START, s, stamp);
                open_slot[s] = 1'b1;
            end
        end
        else if (pick < 65)
            send_item(sip_pkg::CMD_MARK, s, stamp);
        else if (pick < 90)
            send_item(sip_pkg::CMD_READ, s, stamp);
        else if (pick < 94)
            send_item(3'($urandom_range(sip_pkg::CMD_START, sip_pkg::CMD_READ)),
                      8'($urandom_range(SLOTS, 255)), stamp);
        else if (pick < 97)
            send_item(3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST)),
                      8'($urandom), stamp);
        else if (pick < 99)
            send_item(sip_pkg::CMD_END, s, stamp);
        else
            send_item(sip_pkg::CMD_CLEAR, 8'($urandom), stamp);
    endtask

    task automatic test_reset_state();
        send_item(sip_pkg::CMD_READ, 8'd0, 63'd5);
        send_item(sip_pkg::CMD_READ, 8'(SLOTS - 1), STAMP_MAX);
    endtask

    task automatic test_interval_stats();
        send_item(sip_pkg::CMD_START, 8'd0, 63'd100);
        send_item(sip_pkg::CMD_END, 8'd0, 63'd350);
        send_item(sip_pkg::CMD_END, 8'd0, 63'd600);
        send_item(sip_pkg::CMD_MARK, 8'd0, 63'd700);
        send_item(sip_pkg::CMD_READ, 8'd0, 63'd1000);
    endtask

    task automatic test_end_before_start();
        send_item(sip_pkg::CMD_START, 8'd1, 63'd1000);
        send_item(sip_pkg::CMD_END, 8'd1, 63'd400);
        send_item(sip_pkg::CMD_READ, 8'd1, 63'd400);
    endtask

    // full-range interval twice wraps the total negative
    task automatic test_stamp_extremes();
        send_item(sip_pkg::CMD_START, 8'(SLOTS - 1), 63'd0);
        send_item(sip_pkg::CMD_END, 8'(SLOTS - 1), STAMP_MAX);
        send_item(sip_pkg::CMD_END, 8'(SLOTS - 1), STAMP_MAX);
        send_item(sip_pkg::CMD_MARK, 8'(SLOTS - 1), STAMP_MAX);
        send_item(sip_pkg::CMD_READ, 8'(SLOTS - 1), 63'd0);
        send_item(sip_pkg::CMD_MARK, 8'd2, 63'd0);
        send_item(sip_pkg::CMD_READ, 8'd2, 63'd77);
    endtask

    task automatic test_ignored_items();
        send_item(sip_pkg::CMD_START, 8'(SLOTS), 63'd10);
        send_item(sip_pkg::CMD_END, 8'd255, 63'd20);
        send_item(sip_pkg::CMD_READ, 8'd200, 63'd30);
        send_item(sip_pkg::CMD_MARK, 8'd128, 63'd40);
        send_item(CMD_SPARE_FIRST, 8'd0, STAMP_MAX);
        send_item(CMD_SPARE_FIRST + 3'd1, 8'd1, 63'd0);
        send_item(CMD_SPARE_LAST, 8'(SLOTS - 1), 63'd123);
    endtask

    task automatic test_clear_all();
        send_item(sip_pkg::CMD_CLEAR, 8'd255, 63'd0);
        send_item(sip_pkg::CMD_READ, 8'd0, 63'd50);
    endtask

    task automatic test_random_traffic(input int n_items);
        repeat (n_items) send_random_item();
    endtask

    task automatic test_drain_pause();
        repeat (12) send_random_item();
        drain_results();
        repeat (12) send_random_item();
    endtask

    task automatic test_steady_tail(input int n_items);
        idling_on = 1'b0;
        repeat (n_items) send_random_item();
    endtask

    // receiver stall bursts
    always @(negedge clk)
    begin
        if (!idling_on || rst_n !== 1'b1)
        begin
            stall_left = 0;
            out_stall <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(1, 19) - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (pending_reports.size() == 0)
                report_mismatch($sformatf("report with none pending, count %0d",
                                          sample_count));
            else
            begin
                report_want = pending_reports.pop_front();
                check_field("slot_empty", 64'(slot_empty), 64'(report_want.empty));
                check_field("sample_count", 64'(sample_count), 64'(report_want.count));
                check_field("worst_ticks", 64'(worst_ticks), 64'(report_want.worst));
                check_field("total_ticks", total_ticks, report_want.total);
                check_field("average_ticks", average_ticks, report_want.average);
                check_field("last_valid", 64'(last_valid), 64'(report_want.last_ok));
                check_field("ticks_since_last", ticks_since_last, report_want.since);
                reports_checked++;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        command = sip_pkg::CMD_START;
        slot = '0;
        now_ticks = '0;
        idling_on = 1'b1;
        tick_clock = 63'd1;
        items_sent = 0;
        clear_model();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_interval_stats();
        test_end_before_start();
        test_stamp_extremes();
        test_ignored_items();
        test_clear_all();
        test_random_traffic(1550);
        test_drain_pause();
        test_steady_tail(200);

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_reports.size() != 0)
            report_mismatch($sformatf("%0d reports never arrived", pending_reports.size()));

        $display("Run covered %0d items (start, end, mark, read, clear, ignored) and %0d reports",
                 items_sent, reports_checked);
        $display("Mismatches counted: %0d", error_count);
        if (error_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

`default_nettype wire
